[rtl/core/prr_pkg.sv]
// shared widths, codes, control structs and arithmetic helpers of the phase rotator
package prr_pkg;

    // fixed field formats
    localparam int IN_WIDTH        = 18;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int PHASE_FRAC_BITS = 16;
    localparam int PHASE_WIDTH     = PHASE_FRAC_BITS + 2;

    // arithmetic widths
    localparam int PROD_W = 2 * IN_WIDTH;            // one signed product
    localparam int ACC_W  = PROD_W + 2;              // sum of two products plus rounding
    localparam int RND_W  = ACC_W - PHASE_FRAC_BITS; // after the rounding shift
    localparam int SQ_W   = PROD_W;                  // re^2 + im^2
    localparam int MAG_W  = SQ_W / 2;                // integer square root
    localparam int Q_W    = PHASE_WIDTH - 1;         // quotient magnitude before saturation
    localparam int NUM_W  = PHASE_WIDTH + PHASE_FRAC_BITS;
    localparam int DVS_W  = MAG_W + Q_W;

    localparam int SQRT_STEPS = MAG_W;
    localparam int DIV_STEPS  = Q_W;
    localparam int STEP_CNT_W = 5;

    localparam logic [SQ_W-1:0] SQRT_BIT_INIT = SQ_W'(1) << (SQ_W - 2);
    localparam logic [Q_W-1:0]  Q_SAT         = {Q_W{1'b1}};

    // stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IM = 2'd1;

    // input kinds
    localparam logic CMD_ROTATE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // multiplier operand selection
    localparam logic [1:0] MUL_SAMPLE = 2'd0;
    localparam logic [1:0] MUL_STEP   = 2'd1;
    localparam logic [1:0] MUL_SQUARE = 2'd2;

    localparam logic signed [RND_W-1:0] SMP_MAX = RND_W'((2 ** (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [RND_W-1:0] SMP_MIN = -SMP_MAX - RND_W'(1);
    localparam logic signed [RND_W-1:0] PHS_MAX = RND_W'((2 ** (PHASE_WIDTH - 1)) - 1);
    localparam logic signed [RND_W-1:0] PHS_MIN = -PHS_MAX - RND_W'(1);

    typedef struct packed {
        logic [1:0] mul_op;
        logic       y_load;
        logic       phs_update;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_write;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic renorm_due;
        logic out_free;
    } status_t;

    // round half up at the fraction point
    function automatic logic signed [RND_W-1:0] round_q(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + ACC_W'(2 ** (PHASE_FRAC_BITS - 1));
        return t[ACC_W-1:PHASE_FRAC_BITS];
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [RND_W-1:0] v);
        logic signed [RND_W-1:0] c;
        c = v;
        if (v > SMP_MAX)
        begin
            c = SMP_MAX;
        end
        else if (v < SMP_MIN)
        begin
            c = SMP_MIN;
        end
        return c[SAMPLE_WIDTH-1:0];
    endfunction

    function automatic logic signed [PHASE_WIDTH-1:0] sat_phase(
        input logic signed [RND_W-1:0] v);
        logic signed [RND_W-1:0] c;
        c = v;
        if (v > PHS_MAX)
        begin
            c = PHS_MAX;
        end
        else if (v < PHS_MIN)
        begin
            c = PHS_MIN;
        end
        return c[PHASE_WIDTH-1:0];
    endfunction

endpackage

[rtl/core/phase_rotator_renorm_core.sv]
// top level of the complex phase rotator with periodic phasor renormalisation
//
// usage
//   s_axis carries one beat per sample: tdata holds sample_re and sample_im,
//   tuser the command (rotate or load phasor), tlast marks the end of a frame.
//   a rotate beat multiplies the sample by the stored phasor, rounds and
//   saturates it to Q1.15, then advances the phasor by the step phasor.
//   a load beat overwrites the phasor and produces no result beat.
//   m_axis returns one beat per rotate beat: rotated sample and the phasor
//   after its update. the cfg channel writes the step phasor (index 0 real,
//   index 1 imaginary) and is always ready; write it only while idle.
// sequence
//   a rotate beat runs a sample multiply, a phasor multiply and the phasor
//   update; one that ends a renorm interval or carries tlast then also runs
//   an 18-step square root and a 17-step divide, one bit per cycle each.
//   a load beat is taken in idle and leaves the block ready for the next beat.
// reset
//   phasor returns to 1.0, step phasor to 1.0, sample counter to zero.
// back-pressure
//   the result sits in an output register; the next beat is taken meanwhile
//   and processing only waits at the final write if m_axis is still stalled.
module phase_rotator_renorm_core #(
    parameter int RENORM_INTERVAL = 256
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [prr_pkg::S_TDATA_W-1:0]         s_axis_tdata,  // sample_re[17:0], sample_im[35:18]
    input  logic                                  s_axis_tuser,  // command
    input  logic                                  s_axis_tlast,  // block_end
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [prr_pkg::M_TDATA_W-1:0]         m_axis_tdata,  // out_re[15:0], out_im[31:16],
                                                                 // phasor_re[49:32], phasor_im[67:50]
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [prr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [prr_pkg::IN_WIDTH-1:0]          cfg_data
);

    prr_pkg::cmd_t    cmd;
    prr_pkg::status_t status;

    logic in_beat;

    logic signed [prr_pkg::SAMPLE_WIDTH-1:0] out_re, out_im;
    logic signed [prr_pkg::PHASE_WIDTH-1:0]  out_phs_re, out_phs_im;

    // configuration never back-pressures
    assign cfg_ready = 1'b1;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    prr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    prr_datapath #(
        .RENORM_INTERVAL (RENORM_INTERVAL)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_beat    (in_beat),
        .in_cmd     (s_axis_tuser),
        .in_re      (s_axis_tdata[prr_pkg::IN_WIDTH-1:0]),
        .in_im      (s_axis_tdata[2*prr_pkg::IN_WIDTH-1:prr_pkg::IN_WIDTH]),
        .in_last    (s_axis_tlast),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_re     (out_re),
        .out_im     (out_im),
        .out_phs_re (out_phs_re),
        .out_phs_im (out_phs_im)
    );

    // pack the result beat, upper padding bits held at zero
    assign m_axis_tdata = {
        (prr_pkg::M_TDATA_W - 2 * prr_pkg::SAMPLE_WIDTH - 2 * prr_pkg::PHASE_WIDTH)'(0),
        out_phs_im, out_phs_re, out_im, out_re
    };

endmodule

[rtl/core/prr_ctrl.sv]
// sequencer of the phase rotator: steps the datapath through rotate, update and renormalise
module prr_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_cmd,
    output logic           in_ready,
    input  prr_pkg::status_t status,
    output prr_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MUL_Y     = 4'd1;
    localparam logic [3:0] S_MUL_P     = 4'd2;
    localparam logic [3:0] S_UPD       = 4'd3;
    localparam logic [3:0] S_SQ        = 4'd4;
    localparam logic [3:0] S_SQRT_INIT = 4'd5;
    localparam logic [3:0] S_SQRT      = 4'd6;
    localparam logic [3:0] S_DIV_INIT  = 4'd7;
    localparam logic [3:0] S_DIV       = 4'd8;
    localparam logic [3:0] S_DIV_WR    = 4'd9;
    localparam logic [3:0] S_FIN       = 4'd10;

    logic [3:0]                        state_reg, state_next;
    logic [prr_pkg::STEP_CNT_W-1:0]    step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.mul_op = prr_pkg::MUL_SAMPLE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_cmd == prr_pkg::CMD_ROTATE)
                begin
                    state_next = S_MUL_Y;
                end
            end
            S_MUL_Y:
            begin
                cmd.mul_op = prr_pkg::MUL_SAMPLE;
                state_next = S_MUL_P;
            end
            S_MUL_P:
            begin
                cmd.mul_op = prr_pkg::MUL_STEP;
                cmd.y_load = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.phs_update = 1'b1;
                state_next     = status.renorm_due ? S_SQ : S_FIN;
            end
            S_SQ:
            begin
                cmd.mul_op = prr_pkg::MUL_SQUARE;
                state_next = S_SQRT_INIT;
            end
            S_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == prr_pkg::STEP_CNT_W'(prr_pkg::SQRT_STEPS - 1))
                begin
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == prr_pkg::STEP_CNT_W'(prr_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_DIV_WR;
                end
            end
            S_DIV_WR:
            begin
                cmd.div_write = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // a result is only written into a free or draining output register
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending beat");

    // a rotate beat starts the sample multiply on the next cycle
    a_rotate_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_cmd == prr_pkg::CMD_ROTATE) |=> (state_reg == S_MUL_Y))
        else $error("rotate beat did not start the datapath");

    // no renormalisation unless the counter or the frame end asks for it
    a_no_spurious_renorm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && !status.renorm_due) |=> (state_reg == S_FIN))
        else $error("renormalisation entered without cause");

    // iteration counter stays below the root length in both the root and divide loops
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT || state_reg == S_DIV) |->
            (step_reg < prr_pkg::STEP_CNT_W'(prr_pkg::SQRT_STEPS)))
        else $error("iteration counter overran");

endmodule

[rtl/core/prr_datapath.sv]
// datapath of the phase rotator: multipliers, phasor state, root and divide iterations
module prr_datapath #(
    parameter int RENORM_INTERVAL = 256
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [prr_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic signed [prr_pkg::IN_WIDTH-1:0]       cfg_data,
    input  logic                                      in_beat,
    input  logic                                      in_cmd,
    input  logic signed [prr_pkg::IN_WIDTH-1:0]       in_re,
    input  logic signed [prr_pkg::IN_WIDTH-1:0]       in_im,
    input  logic                                      in_last,
    input  prr_pkg::cmd_t                             cmd,
    output prr_pkg::status_t                          status,
    input  logic                                      out_ready,
    output logic                                      out_valid,
    output logic signed [prr_pkg::SAMPLE_WIDTH-1:0]   out_re,
    output logic signed [prr_pkg::SAMPLE_WIDTH-1:0]   out_im,
    output logic signed [prr_pkg::PHASE_WIDTH-1:0]    out_phs_re,
    output logic signed [prr_pkg::PHASE_WIDTH-1:0]    out_phs_im
);

    localparam int CNT_W = (RENORM_INTERVAL > 1) ? $clog2(RENORM_INTERVAL) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RENORM_INTERVAL - 1);

    localparam int IW = prr_pkg::IN_WIDTH;
    localparam int PW = prr_pkg::PHASE_WIDTH;

    logic signed [IW-1:0] step_re_reg, step_im_reg;
    logic signed [IW-1:0] smp_re_reg, smp_im_reg;
    logic                 last_reg;
    logic signed [PW-1:0] phs_re_reg, phs_im_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic signed [IW-1:0]                   op_a [4];
    logic signed [IW-1:0]                   op_b [4];
    logic signed [prr_pkg::PROD_W-1:0]      prod_reg [4];

    logic signed [prr_pkg::ACC_W-1:0]       acc_re, acc_im;
    logic signed [prr_pkg::SAMPLE_WIDTH-1:0] y_re_reg, y_im_reg;

    logic [prr_pkg::SQ_W-1:0]   rx_reg, rr_reg, rbit_reg;
    logic [prr_pkg::SQ_W:0]     sq_try;
    logic [prr_pkg::MAG_W-1:0]  mag;

    logic [prr_pkg::DVS_W-1:0]  dvs_reg;
    logic [prr_pkg::NUM_W-1:0]  rem_reg [2];
    logic [prr_pkg::Q_W-1:0]    q_reg [2];
    logic                       ovf_reg [2];
    logic [PW-1:0]              abs_v [2];
    logic [prr_pkg::NUM_W-1:0]  num [2];
    logic signed [PW-1:0]       norm [2];
    logic                       neg [2];

    logic out_valid_reg;

    // operand selection for the four shared multipliers
    always_comb
    begin
        case (cmd.mul_op)
            prr_pkg::MUL_SAMPLE:
            begin
                op_a[0] = smp_re_reg; op_b[0] = phs_re_reg;
                op_a[1] = smp_im_reg; op_b[1] = phs_im_reg;
                op_a[2] = smp_re_reg; op_b[2] = phs_im_reg;
                op_a[3] = smp_im_reg; op_b[3] = phs_re_reg;
            end
            prr_pkg::MUL_STEP:
            begin
                op_a[0] = phs_re_reg; op_b[0] = step_re_reg;
                op_a[1] = phs_im_reg; op_b[1] = step_im_reg;
                op_a[2] = phs_re_reg; op_b[2] = step_im_reg;
                op_a[3] = phs_im_reg; op_b[3] = step_re_reg;
            end
            default:
            begin
                op_a[0] = phs_re_reg; op_b[0] = phs_re_reg;
                op_a[1] = phs_im_reg; op_b[1] = phs_im_reg;
                op_a[2] = phs_re_reg; op_b[2] = phs_im_reg;
                op_a[3] = phs_im_reg; op_b[3] = phs_re_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_reg[i] <= op_a[i] * op_b[i];
        end
    end

    // complex sum of the registered products
    assign acc_re = prr_pkg::ACC_W'(prod_reg[0]) - prr_pkg::ACC_W'(prod_reg[1]);
    assign acc_im = prr_pkg::ACC_W'(prod_reg[2]) + prr_pkg::ACC_W'(prod_reg[3]);

    assign status.renorm_due = (cnt_reg == CNT_LAST) || last_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    // square root, one result bit per step
    assign sq_try = {1'b0, rr_reg} + {1'b0, rbit_reg};
    assign mag    = rr_reg[prr_pkg::MAG_W-1:0];

    always_comb
    begin
        abs_v[0] = phs_re_reg[PW-1] ? PW'(-phs_re_reg) : PW'(phs_re_reg);
        abs_v[1] = phs_im_reg[PW-1] ? PW'(-phs_im_reg) : PW'(phs_im_reg);
        neg[0]   = phs_re_reg[PW-1];
        neg[1]   = phs_im_reg[PW-1];
        for (int k = 0; k < 2; k++)
        begin
            num[k]  = (prr_pkg::NUM_W'(abs_v[k]) << prr_pkg::PHASE_FRAC_BITS)
                    + prr_pkg::NUM_W'(mag >> 1);
            norm[k] = ovf_reg[k] ? PW'({1'b0, prr_pkg::Q_SAT}) : PW'({1'b0, q_reg[k]});
            if (neg[k])
            begin
                norm[k] = -norm[k];
            end
        end
    end

    // root and quotient registers
    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            rx_reg   <= prr_pkg::SQ_W'(prod_reg[0][prr_pkg::SQ_W-2:0])
                      + prr_pkg::SQ_W'(prod_reg[1][prr_pkg::SQ_W-2:0]);
            rr_reg   <= '0;
            rbit_reg <= prr_pkg::SQRT_BIT_INIT;
        end
        else if (cmd.sqrt_step)
        begin
            if ({1'b0, rx_reg} >= sq_try)
            begin
                rx_reg <= rx_reg - sq_try[prr_pkg::SQ_W-1:0];
                rr_reg <= (rr_reg >> 1) + rbit_reg;
            end
            else
            begin
                rr_reg <= rr_reg >> 1;
            end
            rbit_reg <= rbit_reg >> 2;
        end

        if (cmd.div_init)
        begin
            dvs_reg <= prr_pkg::DVS_W'(mag) << (prr_pkg::Q_W - 1);
            for (int k = 0; k < 2; k++)
            begin
                rem_reg[k] <= num[k];
                q_reg[k]   <= '0;
                ovf_reg[k] <= {1'b0, num[k]} >= (prr_pkg::DVS_W'(mag) << prr_pkg::Q_W);
            end
        end
        else if (cmd.div_step)
        begin
            for (int k = 0; k < 2; k++)
            begin
                if ({1'b0, rem_reg[k]} >= dvs_reg)
                begin
                    rem_reg[k] <= rem_reg[k] - dvs_reg[prr_pkg::NUM_W-1:0];
                    q_reg[k]   <= {q_reg[k][prr_pkg::Q_W-2:0], 1'b1};
                end
                else
                begin
                    q_reg[k] <= {q_reg[k][prr_pkg::Q_W-2:0], 1'b0};
                end
            end
            dvs_reg <= dvs_reg >> 1;
        end
    end

    // captured beat, rotated sample and output result registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            smp_re_reg <= in_re;
            smp_im_reg <= in_im;
            last_reg   <= in_last;
        end
        if (cmd.y_load)
        begin
            y_re_reg <= prr_pkg::sat_sample(prr_pkg::round_q(acc_re));
            y_im_reg <= prr_pkg::sat_sample(prr_pkg::round_q(acc_im));
        end
        if (cmd.out_load)
        begin
            out_re     <= y_re_reg;
            out_im     <= y_im_reg;
            out_phs_re <= phs_re_reg;
            out_phs_im <= phs_im_reg;
        end
    end

    // step phasor, phasor, sample counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_re_reg   <= IW'(2 ** prr_pkg::PHASE_FRAC_BITS);
            step_im_reg   <= '0;
            phs_re_reg    <= PW'(2 ** prr_pkg::PHASE_FRAC_BITS);
            phs_im_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == prr_pkg::REG_STEP_RE)
            begin
                step_re_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == prr_pkg::REG_STEP_IM)
            begin
                step_im_reg <= cfg_data;
            end

            if (in_beat && in_cmd == prr_pkg::CMD_LOAD)
            begin
                phs_re_reg <= in_re;
                phs_im_reg <= in_im;
            end
            else if (cmd.phs_update)
            begin
                phs_re_reg <= prr_pkg::sat_phase(prr_pkg::round_q(acc_re));
                phs_im_reg <= prr_pkg::sat_phase(prr_pkg::round_q(acc_im));
                cnt_reg    <= status.renorm_due ? '0 : cnt_reg + 1'b1;
            end
            else if (cmd.div_write && mag != '0)
            begin
                phs_re_reg <= norm[0];
                phs_im_reg <= norm[1];
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[sim/phase_rotator_renorm_core_tb.sv]
// self-checking testbench for the phase rotator: directed corner beats, then random traffic, framed in some phases
module phase_rotator_renorm_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prr_pkg::*;

    // must match the parameter of the instance below
    localparam int RENORM_INTERVAL = 256;
    // longer than the slowest beat, one that renormalises, needs to return to ready, so any work in flight is covered
    localparam int DRAIN_CYCLES = 64;
    // long receiver stall, enough to fill the output register and stall s_axis
    localparam int HOLD_CYCLES = 400;
    localparam int N_PHASES = 7;

    // register indexes with no register behind them, writes to them are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;  // sample_re[17:0], sample_im[35:18]
    logic                   s_axis_tuser;  // command
    logic                   s_axis_tlast;  // block_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;  // out_re[15:0], out_im[31:16],
                                           // phasor_re[49:32], phasor_im[67:50]
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [IN_WIDTH-1:0]    cfg_data;

    // one expected result beat, all fields held as plain signed numbers
    typedef struct {
        longint y_re;
        longint y_im;
        longint ph_re;
        longint ph_im;
    } mix_result_t;

    // mixer predictor plus the queue of results still owed by the block
    class rotator_scoreboard;
        longint      step_re;
        longint      step_im;
        longint      ph_re;
        longint      ph_im;
        int          since_renorm;
        int          errors;
        mix_result_t expected_mix_q[$];

        function new();
            step_re      = 64'sd1 <<< PHASE_FRAC_BITS;
            step_im      = 0;
            ph_re        = 64'sd1 <<< PHASE_FRAC_BITS;
            ph_im        = 0;
            since_renorm = 0;
            errors       = 0;
        endfunction

        function longint sat_to(longint v, int w);
            longint hi;
            hi = (64'sd1 <<< (w - 1)) - 1;
            if (v > hi)
                return hi;
            if (v < -hi - 1)
                return -hi - 1;
            return v;
        endfunction

        // round half up at the binary point, arithmetic shift gives the floor
        function longint round_frac(longint v);
            return (v + (64'sd1 <<< (PHASE_FRAC_BITS - 1))) >>> PHASE_FRAC_BITS;
        endfunction

        function longint int_sqrt(longint x);
            longint r;
            longint probe;
            r     = 0;
            probe = 64'sd1 <<< 62;
            while (probe > x)
                probe = probe >>> 2;
            while (probe != 0)
            begin
                if (x >= r + probe)
                begin
                    x = x - (r + probe);
                    r = (r >>> 1) + probe;
                end
                else
                begin
                    r = r >>> 1;
                end
                probe = probe >>> 2;
            end
            return r;
        endfunction

        // |v| * 2^frac / mag rounded half away from zero, sign put back afterwards
        function longint norm_part(longint v, longint mag);
            longint a;
            longint q;
            longint r;
            a = (v < 0) ? -v : v;
            q = ((a <<< PHASE_FRAC_BITS) + (mag >>> 1)) / mag;
            if (q > (64'sd1 <<< 40))
                q = 64'sd1 <<< 40;
            r = sat_to(q, PHASE_WIDTH);
            return (v < 0) ? sat_to(-r, PHASE_WIDTH) : r;
        endfunction

        function void renormalise();
            longint a;
            longint b;
            longint mag;
            a   = (ph_re < 0) ? -ph_re : ph_re;
            b   = (ph_im < 0) ? -ph_im : ph_im;
            mag = int_sqrt(a * a + b * b);
            // zero magnitude leaves the phasor alone
            if (mag == 0)
                return;
            ph_re = norm_part(ph_re, mag);
            ph_im = norm_part(ph_im, mag);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic signed [IN_WIDTH-1:0] value);
            case (idx)
                REG_STEP_RE: step_re = value;
                REG_STEP_IM: step_im = value;
                default: ;
            endcase
        endfunction

        // called for every s_axis beat the block takes
        function void accept_beat(logic cmd, logic signed [IN_WIDTH-1:0] re,
                                  logic signed [IN_WIDTH-1:0] im, logic last);
            longint      sr;
            longint      si;
            longint      nr;
            longint      ni;
            mix_result_t r;
            sr = re;
            si = im;
            if (cmd == CMD_LOAD)
            begin
                // tlast and the sample counter are untouched by a load
                ph_re = sat_to(sr, PHASE_WIDTH);
                ph_im = sat_to(si, PHASE_WIDTH);
                return;
            end
            r.y_re = sat_to(round_frac(sr * ph_re - si * ph_im), SAMPLE_WIDTH);
            r.y_im = sat_to(round_frac(sr * ph_im + si * ph_re), SAMPLE_WIDTH);
            nr = ph_re * step_re - ph_im * step_im;
            ni = ph_re * step_im + ph_im * step_re;
            ph_re = sat_to(round_frac(nr), PHASE_WIDTH);
            ph_im = sat_to(round_frac(ni), PHASE_WIDTH);
            since_renorm++;
            if (since_renorm >= RENORM_INTERVAL || last)
            begin
                renormalise();
                since_renorm = 0;
            end
            r.ph_re = ph_re;
            r.ph_im = ph_im;
            expected_mix_q.push_back(r);
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_mix_result(logic [M_TDATA_W-1:0] beat);
            mix_result_t want;
            if (expected_mix_q.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with none expected, expected nothing, actual %h",
                         $time, beat);
                return;
            end
            want = expected_mix_q.pop_front();
            compare_field("out_re", want.y_re, $signed(beat[SAMPLE_WIDTH-1:0]));
            compare_field("out_im", want.y_im, $signed(beat[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));
            compare_field("phasor_re", want.ph_re,
                          $signed(beat[2*SAMPLE_WIDTH +: PHASE_WIDTH]));
            compare_field("phasor_im", want.ph_im,
                          $signed(beat[2*SAMPLE_WIDTH+PHASE_WIDTH +: PHASE_WIDTH]));
        endfunction

        function int outstanding();
            return expected_mix_q.size();
        endfunction
    endclass

    rotator_scoreboard sb = new();

    // sender pacing: redrawn every 32 beats, burst means no gaps at all
    int in_beats     = 0;
    bit burst_in     = 1'b0;
    int results_seen = 0;

    // random phase plan: beats per phase and whether frames end in tlast
    int phase_items [N_PHASES] = '{400, 300, 100, 60, 350, 150, 150};
    bit phase_framed[N_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    phase_rotator_renorm_core #(
        .RENORM_INTERVAL (RENORM_INTERVAL)
    )
    u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // any 18-bit two's complement value
    function automatic int rand_full();
        return int'($urandom_range(0, 262143)) - 131072;
    endfunction

    // mostly Q1.15 range, now and then the full field so the output saturates
    function automatic int rand_sample();
        if ($urandom_range(0, 15) == 0)
            return rand_full();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // one s_axis beat; returns at the rising edge where it was taken
    task automatic send_beat(input logic cmd, input int re, input int im, input logic last);
        int gap;
        if (in_beats % 32 == 0)
            burst_in = ($urandom_range(0, 3) == 0);
        in_beats++;
        gap = burst_in ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({IN_WIDTH'(im), IN_WIDTH'(re)});
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.accept_beat(cmd, IN_WIDTH'(re), IN_WIDTH'(im), last);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= IN_WIDTH'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, IN_WIDTH'(value));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering, wait for every owed result, then let a trailing load or renorm settle
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // random traffic: mostly frames of rotate beats, some preceded by a phasor load,
    // with one draw in ten a single beat of pure noise across every field
    task automatic run_phase(input int n_items, input bit framed);
        int  sent;
        int  len;
        int  k;
        real ang;
        real gain;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_beat(logic'($urandom_range(0, 1)), rand_full(), rand_full(),
                          framed ? logic'($urandom_range(0, 1)) : 1'b0);
                sent++;
            end
            else
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    // unit phasor at a random angle, sometimes off magnitude for the renorm
                    ang  = $urandom_range(0, 62831) / 10000.0;
                    gain = ($urandom_range(0, 3) == 0) ? 0.5 + $urandom_range(0, 1400) / 1000.0
                                                        : 1.0;
                    send_beat(CMD_LOAD, int'(65536.0 * gain * $cos(ang)),
                              int'(65536.0 * gain * $sin(ang)), 1'b0);
                    sent++;
                end
                // the odd long frame can run past the renorm interval
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 40);
                for (k = 0; k < len; k++)
                begin
                    send_beat(CMD_ROTATE, rand_sample(), rand_sample(), framed && (k == len - 1));
                    sent++;
                end
            end
        end
    endtask

    // result side: random stalls, bursts of full rate, and two long hold-offs
    initial
    begin
        int gap;
        int beats;
        bit burst_out;
        m_axis_tready = 1'b0;
        beats         = 0;
        burst_out     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (beats % 32 == 0)
                burst_out = ($urandom_range(0, 3) == 0);
            gap = burst_out ? 0 : $urandom_range(0, 10);
            // back-pressure long enough for the block to stop taking samples
            if (results_seen == 150 || results_seen == 700)
                gap = HOLD_CYCLES;
            @(negedge clk);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_mix_result(m_axis_tdata);
            results_seen++;
            beats++;
        end
    end

    // stimulus
    initial
    begin
        int  p;
        int  step_r;
        int  step_i;
        real ang;
        real gain;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_ROTATE;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_STEP_RE;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset phasor and unit step: sample extremes and an oversized sample
        send_beat(CMD_ROTATE, 32767, 32767, 1'b0);
        send_beat(CMD_ROTATE, -32768, -32768, 1'b0);
        send_beat(CMD_ROTATE, 0, 0, 1'b0);
        send_beat(CMD_ROTATE, 131071, -131072, 1'b0);
        // load with tlast set, the flag is ignored on a load
        send_beat(CMD_LOAD, 131071, 131071, 1'b1);
        send_beat(CMD_ROTATE, 32767, -32768, 1'b1);
        send_beat(CMD_LOAD, -131072, -131072, 1'b0);
        send_beat(CMD_ROTATE, -32768, 32767, 1'b1);
        // zero phasor: renorm has nothing to divide by
        send_beat(CMD_LOAD, 0, 0, 1'b0);
        send_beat(CMD_ROTATE, 12345, -2345, 1'b1);
        send_beat(CMD_ROTATE, 100, 100, 1'b0);
        send_beat(CMD_LOAD, 65536, 0, 1'b0);
        send_beat(CMD_ROTATE, -131072, 131071, 1'b1);

        // extreme step so the phasor overflows and saturates, spare indexes dropped
        wait_idle();
        write_reg(REG_STEP_RE, 131071);
        write_reg(REG_STEP_IM, -131072);
        write_reg(REG_SPARE_A, 0);
        write_reg(REG_SPARE_B, 131071);
        send_beat(CMD_LOAD, 131071, 0, 1'b0);
        send_beat(CMD_ROTATE, 1000, -1000, 1'b0);
        send_beat(CMD_ROTATE, 1000, -1000, 1'b0);
        send_beat(CMD_ROTATE, 1000, -1000, 1'b0);
        send_beat(CMD_LOAD, -131072, 131071, 1'b0);
        send_beat(CMD_ROTATE, 32767, 32767, 1'b1);

        // random phases, each under its own step phasor
        for (p = 0; p < N_PHASES; p++)
        begin
            wait_idle();
            ang  = $urandom_range(0, 62831) / 10000.0;
            gain = 1.0;
            case (p)
                0: ang = 0.01;
                1: ang = -0.3;
                4: gain = 1.002;
                6: ang = 3.14159265;
                default: ;
            endcase
            step_r = int'(65536.0 * gain * $cos(ang));
            step_i = int'(65536.0 * gain * $sin(ang));
            case (p)
                2:
                begin
                    step_r = -131072;
                    step_i = 131071;
                end
                3:
                begin
                    step_r = 0;
                    step_i = 0;
                end
                5:
                begin
                    step_r = rand_full();
                    step_i = rand_full();
                end
                default: ;
            endcase
            write_reg(REG_STEP_RE, step_r);
            write_reg(REG_STEP_IM, step_i);
            run_phase(phase_items[p], phase_framed[p]);
        end

        wait_idle();
        if (sb.errors == 0)
            $display("** phase_rotator_renorm_core: PASSED **");
        else
            $display("** phase_rotator_renorm_core: FAILED **");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #10_000_000;
        $display("** phase_rotator_renorm_core: FAILED **");
        $finish;
    end

endmodule
